// File: rtl/fbns_pkg.sv
package fbns_pkg;

  // Fixed field widths
  localparam int unsigned NoteW  = 7;
  localparam int unsigned CountW = 7;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [PhaseW-1:0] TickDivReset   = 8'd24;
  localparam logic [CountW-1:0] MaxBlocksReset = 7'd10;
  localparam logic [NoteW-1:0]  BaseNoteReset  = 7'd36;

  localparam logic [NoteW-1:0] VelocityOn  = 7'd127;
  localparam logic [NoteW-1:0] VelocityOff = 7'd0;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICK_DIV   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BLOCKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_NOTE  = 2'd2;

  // Command codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [2:0] key_row;
    logic [3:0] key_col;
  } fbns_in_t;

  typedef struct packed {
    logic             note_on;
    logic [NoteW-1:0] note_number;
    logic [NoteW-1:0] velocity;
    logic             last_event;
  } fbns_out_t;

  // Control from the sequencer to the event buffer
  typedef struct packed {
    logic             push;
    logic             on;
    logic [NoteW-1:0] note;
    logic             flush;
  } fbns_evt_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } fbns_state_e;

endpackage

// File: rtl/fbns_col_step.sv
module fbns_col_step #(
  parameter int unsigned ROWS = 8
) (
  input  logic [ROWS-1:0] old_col_i,
  input  logic            recycle_i,
  output logic [ROWS-1:0] next_col_o,
  output logic            ev_valid_o,
  output logic            ev_on_o,
  output logic            drop_o
);

  // Move every block down one row, wrap the bottom one if recycling
  assign next_col_o = {old_col_i[ROWS-2:0], old_col_i[ROWS-1] & recycle_i};

  // Arrival on the bottom row wins over a bottom row going empty
  assign ev_on_o    = old_col_i[ROWS-2];
  assign ev_valid_o = old_col_i[ROWS-2] | old_col_i[ROWS-1];

  // A block leaves the grid
  assign drop_o = old_col_i[ROWS-1] & ~recycle_i;

endmodule

// File: rtl/fbns_evt_buf.sv
module fbns_evt_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fbns_pkg::fbns_evt_ctl_t ctl_i,
  output fbns_pkg::fbns_out_t     result_o,
  output logic                    strobe_o
);
  import fbns_pkg::*;

  logic             pend_vld_q, pend_vld_d;
  logic             pend_on_q, pend_on_d;
  logic [NoteW-1:0] pend_note_q, pend_note_d;
  logic             strobe_q, strobe_d;
  fbns_out_t        result_q, result_d;

  // Hold one event back until it is known whether another follows
  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_on_d   = pend_on_q;
    pend_note_d = pend_note_q;
    strobe_d    = 1'b0;
    result_d    = result_q;
    if (ctl_i.push) begin
      pend_vld_d  = 1'b1;
      pend_on_d   = ctl_i.on;
      pend_note_d = ctl_i.note;
    end else if (ctl_i.flush) begin
      pend_vld_d = 1'b0;
    end
    if ((ctl_i.push || ctl_i.flush) && pend_vld_q) begin
      strobe_d             = 1'b1;
      result_d.note_on     = pend_on_q;
      result_d.note_number = pend_note_q;
      result_d.velocity    = pend_on_q ? VelocityOn : VelocityOff;
      result_d.last_event  = ctl_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_on_q   <= pend_on_d;
    pend_note_q <= pend_note_d;
    result_q    <= result_d;
  end

  assign result_o = result_q;
  assign strobe_o = strobe_q;

endmodule

// File: rtl/falling_block_note_sequencer.sv
// Channel  | Ports                             | Transfer
// ---------+-----------------------------------+-----------------------------------
// command  | start, busy, in_i                 | edge with start high and busy low
// result   | out_strobe_o, result_o            | edge with out_strobe_o high
// config   | cfg_we_i, cfg_idx_i, cfg_data_i   | edge with cfg_we_i high
//
// A key press or a tick that does not shift leaves busy low.
// A shifting tick sweeps the columns through one shared column unit, one
// column a cycle, then passes the flush state; busy is high through both.
// Each result leaves in the cycle after its event is followed by the next, the
// final one in the first cycle with busy low again. Reset clears the grid,
// flags, count and phase at once. Results cannot be held off by the receiver.
module falling_block_note_sequencer #(
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned ROWS    = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  fbns_pkg::fbns_in_t                     in_i,
  output logic                                   out_strobe_o,
  output fbns_pkg::fbns_out_t                    result_o,
  input  logic                                   cfg_we_i,
  input  logic [fbns_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [fbns_pkg::CfgDataW-1:0]          cfg_data_i
);
  import fbns_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);
  localparam logic [CW-1:0] LastCol = CW'(COLUMNS - 1);

  fbns_state_e      state_q, state_d;
  logic [CW-1:0]    col_q, col_d;
  logic [ROWS-1:0]  grid_q [COLUMNS];
  logic [COLUMNS-1:0] recycle_q, recycle_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] tick_div_q;
  logic [CountW-1:0] max_blocks_q;
  logic [NoteW-1:0]  base_note_q;

  logic              accept;
  logic              key_ok;
  logic              key_bottom;
  logic [CW-1:0]     rd_idx;
  logic [ROWS-1:0]   rd_col;
  logic [ROWS-1:0]   key_mask;
  logic              grid_we;
  logic [ROWS-1:0]   grid_wdata;
  logic [ROWS-1:0]   step_next;
  logic              step_ev_valid;
  logic              step_ev_on;
  logic              step_drop;
  logic [PhaseW-1:0] div_eff;
  logic [PhaseW-1:0] phase_inc;
  fbns_evt_ctl_t     evt_ctl;

  assign accept     = start && (state_q == ST_IDLE);
  assign key_ok     = (5'(in_i.key_col) < 5'(COLUMNS)) && (5'(in_i.key_row) < 5'(ROWS));
  assign key_bottom = (5'(in_i.key_row) == 5'(ROWS - 1));
  assign key_mask   = {{(ROWS-1){1'b0}}, 1'b1} << in_i.key_row;

  // Single grid port: sweep column in the sweep state, key column otherwise
  assign rd_idx = (state_q == ST_SWEEP) ? col_q : CW'(in_i.key_col);
  assign rd_col = grid_q[rd_idx];

  fbns_col_step #(
    .ROWS(ROWS)
  ) u_col_step (
    .old_col_i (rd_col),
    .recycle_i (recycle_q[rd_idx]),
    .next_col_o(step_next),
    .ev_valid_o(step_ev_valid),
    .ev_on_o   (step_ev_on),
    .drop_o    (step_drop)
  );

  assign div_eff   = (tick_div_q == '0) ? PhaseW'(1) : tick_div_q;
  assign phase_inc = phase_q + PhaseW'(1);

  // Sequencer: next state, grid write and event control
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    recycle_d  = recycle_q;
    count_d    = count_q;
    phase_d    = phase_q;
    grid_we    = 1'b0;
    grid_wdata = step_next;
    evt_ctl    = '0;
    evt_ctl.on   = step_ev_on;
    evt_ctl.note = base_note_q + NoteW'(col_q);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.opcode == OP_KEY) begin
            if (key_ok) begin
              if (key_bottom) begin
                recycle_d[rd_idx] = ~recycle_q[rd_idx];
              end else if ((count_q < max_blocks_q) && ((rd_col & key_mask) == '0)) begin
                grid_we    = 1'b1;
                grid_wdata = rd_col | key_mask;
                count_d    = count_q + CountW'(1);
              end
            end
          end else begin
            if (phase_inc < div_eff) begin
              phase_d = phase_inc;
            end else begin
              phase_d = '0;
              col_d   = '0;
              state_d = ST_SWEEP;
            end
          end
        end
      end
      ST_SWEEP: begin
        grid_we      = 1'b1;
        evt_ctl.push = step_ev_valid;
        if (step_drop && (count_q != '0)) begin
          count_d = count_q - CountW'(1);
        end
        if (col_q == LastCol) begin
          state_d = ST_FLUSH;
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      ST_FLUSH: begin
        evt_ctl.flush = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      recycle_q <= '0;
      count_q   <= '0;
      phase_q   <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      recycle_q <= recycle_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
    end
  end

  // Grid storage, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COLUMNS; i++) begin
        grid_q[i] <= '0;
      end
    end else if (grid_we) begin
      grid_q[rd_idx] <= grid_wdata;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q   <= TickDivReset;
      max_blocks_q <= MaxBlocksReset;
      base_note_q  <= BaseNoteReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_DIV:   tick_div_q   <= cfg_data_i;
        CFG_MAX_BLOCKS: max_blocks_q <= cfg_data_i[CountW-1:0];
        CFG_BASE_NOTE:  base_note_q  <= cfg_data_i[NoteW-1:0];
        default: begin
        end
      endcase
    end
  end

  fbns_evt_buf u_evt_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (evt_ctl),
    .result_o(result_o),
    .strobe_o(out_strobe_o)
  );

  assign busy = (state_q != ST_IDLE);

  // The final event of a sweep leaves only after the sequencer is idle again
  a_last_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && result_o.last_event |-> !busy)
    else $error("last event shown while still sweeping");

  // Non-final events leave only during the sweep or flush state
  a_mid_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !result_o.last_event |-> state_q == ST_SWEEP || state_q == ST_FLUSH)
    else $error("event shown outside a sweep");

  // The sweep visits every column once, in order
  a_sweep_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP && col_q != LastCol |=> state_q == ST_SWEEP &&
    col_q == $past(col_q) + CW'(1))
    else $error("column sweep skipped or stopped");

endmodule

// File: bench/tb_falling_block_note_sequencer.sv
module tb_falling_block_note_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import fbns_pkg::*;

  localparam int unsigned COLS = 8;
  localparam int unsigned ROWS = 8;
  // settle wait after the last predicted result is drained
  localparam int unsigned SETTLE_CYCLES = COLS + 4;
  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned PHASE_ITEMS = 18;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  fbns_in_t in_i = '0;
  logic out_strobe_o;
  fbns_out_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_TICK_DIV;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // mirror of the grid and its registers
  logic [ROWS-1:0] grid_mirror [COLS];
  logic [COLS-1:0] recycle_mirror;
  logic [CountW-1:0] blocks_mirror;
  logic [PhaseW-1:0] phase_mirror;
  logic [PhaseW-1:0] divisor_mirror;
  logic [CountW-1:0] max_blocks_mirror;
  logic [NoteW-1:0] base_note_mirror;

  fbns_out_t pending_notes [$];
  fbns_out_t want_note;

  int mismatches = 0;
  int notes_seen = 0;
  int ticks_sent = 0;
  int keys_sent = 0;
  int settings_applied = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;

  falling_block_note_sequencer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .out_strobe_o(out_strobe_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clear the mirror to its reset contents
  task automatic reset_mirror();
    for (int c = 0; c < COLS; c++) grid_mirror[c] = '0;
    recycle_mirror = '0;
    blocks_mirror = '0;
    phase_mirror = '0;
    divisor_mirror = TickDivReset;
    max_blocks_mirror = MaxBlocksReset;
    base_note_mirror = BaseNoteReset;
  endtask

  // Advance the mirror by one command and queue the note events it causes
  task automatic play_command(input fbns_in_t cmd);
    logic [ROWS-1:0] cur;
    logic [ROWS-1:0] nxt;
    logic [PhaseW-1:0] div_eff;
    fbns_out_t evs [COLS];
    int n;
    n = 0;
    if (cmd.opcode == OP_KEY) begin
      if (cmd.key_col >= COLS || cmd.key_row >= ROWS) return;
      if (cmd.key_row == ROWS - 1) begin
        recycle_mirror[cmd.key_col] = ~recycle_mirror[cmd.key_col];
      end else if (blocks_mirror < max_blocks_mirror &&
                   !grid_mirror[cmd.key_col][cmd.key_row]) begin
        grid_mirror[cmd.key_col][cmd.key_row] = 1'b1;
        blocks_mirror = blocks_mirror + CountW'(1);
      end
      return;
    end
    div_eff = (divisor_mirror == 0) ? 8'd1 : divisor_mirror;
    phase_mirror = phase_mirror + PhaseW'(1);
    if (phase_mirror < div_eff) return;
    phase_mirror = '0;
    // sweep columns in order, each shifting down one row
    for (int c = 0; c < COLS; c++) begin
      cur = grid_mirror[c];
      nxt = cur << 1;
      if (cur[ROWS-2] || cur[ROWS-1]) begin
        evs[n].note_on = cur[ROWS-2];
        evs[n].note_number = base_note_mirror + NoteW'(c);
        evs[n].velocity = cur[ROWS-2] ? VelocityOn : VelocityOff;
        evs[n].last_event = 1'b0;
        n++;
      end
      if (cur[ROWS-1]) begin
        if (recycle_mirror[c]) nxt[0] = 1'b1;
        else if (blocks_mirror > 0) blocks_mirror = blocks_mirror - CountW'(1);
      end
      grid_mirror[c] = nxt;
    end
    if (n > 0) evs[n-1].last_event = 1'b1;
    for (int k = 0; k < n; k++) pending_notes.push_back(evs[k]);
  endtask

  // Predict on every command transfer
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) play_command(in_i);
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare each note event with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      notes_seen++;
      if (pending_notes.size() == 0) begin
        $display("%0t: unexpected note event: expected none, actual %p", $time, result_o);
        mismatches++;
      end else begin
        want_note = pending_notes.pop_front();
        check_field("note_on", want_note.note_on, result_o.note_on);
        check_field("note_number", want_note.note_number, result_o.note_number);
        check_field("velocity", want_note.velocity, result_o.velocity);
        check_field("last_event", want_note.last_event, result_o.last_event);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || out_strobe_o || cfg_we_i) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("tb_falling_block_note_sequencer: FAIL");
        $finish;
      end
    end
  end

  // Send one command; returns at the edge that takes the transfer
  task automatic send_command(input fbns_in_t cmd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd.opcode == OP_TICK) ticks_sent++;
    else keys_sent++;
  endtask

  task automatic press_key(input int row, input int col);
    fbns_in_t cmd;
    cmd.opcode = OP_KEY;
    cmd.key_row = 3'(row);
    cmd.key_col = 4'(col);
    send_command(cmd);
  endtask

  task automatic send_ticks(input int count);
    fbns_in_t cmd;
    for (int i = 0; i < count; i++) begin
      cmd.opcode = OP_TICK;
      cmd.key_row = 3'($urandom_range(0, 7));
      cmd.key_col = 4'($urandom_range(0, 15));
      send_command(cmd);
    end
  endtask

  // Drain all predicted events, then let the sweep settle
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    @(posedge clk_i);
    case (idx)
      CFG_TICK_DIV:   divisor_mirror = PhaseW'(value);
      CFG_MAX_BLOCKS: max_blocks_mirror = CountW'(value);
      CFG_BASE_NOTE:  base_note_mirror = NoteW'(value);
      default: ;
    endcase
    settings_applied++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Draw a mostly well-formed command; returns 1 when the block ignores it
  function automatic bit draw_command(output fbns_in_t cmd);
    int roll;
    roll = $urandom_range(0, 99);
    cmd.opcode = OP_KEY;
    cmd.key_row = 3'($urandom_range(0, 6));
    cmd.key_col = 4'($urandom_range(0, COLS - 1));
    if (roll < 35) begin
      cmd.opcode = OP_TICK;
      cmd.key_row = 3'($urandom_range(0, 7));
      cmd.key_col = 4'($urandom_range(0, 15));
    end else if (roll < 80) begin
      // plain drop, keep fields as drawn
    end else if (roll < 90) begin
      cmd.key_row = 3'(ROWS - 1);
    end else begin
      cmd.key_row = 3'($urandom_range(0, 7));
      cmd.key_col = 4'($urandom_range(COLS, 15));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Lowering the divisor below the running phase shifts on the next tick
  task automatic test_divisor_lowered();
    press_key(ROWS - 2, 0);
    send_ticks(3);
    wait_quiet();
    write_reg(CFG_TICK_DIV, 2);
    send_ticks(1);
  endtask

  // Divisor zero shifts on every tick; stacked blocks retrigger the bottom
  task automatic test_zero_divisor();
    wait_quiet();
    write_reg(CFG_TICK_DIV, 0);
    press_key(ROWS - 3, 1);
    press_key(ROWS - 2, 1);
    send_ticks(3);
  endtask

  // Keys outside the grid columns change nothing
  task automatic test_ignored_keys();
    press_key(0, COLS);
    press_key(ROWS - 1, 15);
    press_key(3, 12);
    send_ticks(1);
  endtask

  // A recycling column wraps its bottom block back to the top
  task automatic test_recycle();
    press_key(ROWS - 1, 2);
    press_key(ROWS - 2, 2);
    send_ticks(2);
    press_key(ROWS - 1, 2);
  endtask

  // Drops beyond the block limit or into an occupied cell are refused
  task automatic test_block_limit();
    wait_quiet();
    write_reg(CFG_MAX_BLOCKS, 0);
    press_key(4, 3);
    wait_quiet();
    write_reg(CFG_MAX_BLOCKS, 2);
    press_key(4, 3);
    press_key(5, 3);
    press_key(4, 3);
    send_ticks(1);
  endtask

  // Note numbers wrap past 127
  task automatic test_note_wrap();
    wait_quiet();
    write_reg(CFG_BASE_NOTE, 125);
    write_reg(CFG_MAX_BLOCKS, 64);
    press_key(ROWS - 2, 3);
    press_key(ROWS - 2, COLS - 1);
    send_ticks(1);
  endtask

  // Largest divisor holds the grid still; lowering it then shifts at once
  task automatic test_slowest_divisor();
    wait_quiet();
    write_reg(CFG_TICK_DIV, 255);
    write_reg(CFG_BASE_NOTE, 0);
    press_key(ROWS - 2, 6);
    send_ticks(6);
    wait_quiet();
    write_reg(CFG_TICK_DIV, 3);
    send_ticks(1);
  endtask

  // Random play over several register settings
  task automatic test_random_play();
    fbns_in_t cmd;
    int counted;
    int div_set [4];
    int max_set [4];
    int base_set [4];
    div_set = '{1, 2, 3, $urandom_range(1, 8)};
    max_set = '{64, 10, 5, $urandom_range(0, 64)};
    base_set = '{120, 0, 60, $urandom_range(0, 127)};
    for (int p = 0; p < 4; p++) begin
      wait_quiet();
      write_reg(CFG_TICK_DIV, div_set[p]);
      write_reg(CFG_MAX_BLOCKS, max_set[p]);
      write_reg(CFG_BASE_NOTE, base_set[p]);
      no_gaps = (p == 1);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (!draw_command(cmd)) counted++;
        send_command(cmd);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    reset_mirror();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_divisor_lowered();
    test_zero_divisor();
    test_ignored_keys();
    test_recycle();
    test_block_limit();
    test_note_wrap();
    test_slowest_divisor();
    test_random_play();
    wait_quiet();
    $display("covered %0d ticks and %0d key presses over %0d register writes,",
             ticks_sent, keys_sent, settings_applied);
    $display("checked %0d note events, %0d mismatches", notes_seen, mismatches);
    if (mismatches == 0 && pending_notes.size() == 0) begin
      $display("tb_falling_block_note_sequencer: PASS");
    end else begin
      $display("tb_falling_block_note_sequencer: FAIL");
    end
    $finish;
  end

endmodule
